// ===== rtl/polar_plotter_step_generator_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef POLAR_PLOTTER_STEP_GENERATOR_UNIT_ASSERT_SVH
`define POLAR_PLOTTER_STEP_GENERATOR_UNIT_ASSERT_SVH

`define PPSG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`define PPSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/ppsg_pkg.sv =====
`timescale 1ns / 1ps

package ppsg_pkg;

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int COORD_W    = 16;
    localparam int OFF_W      = 17;
    localparam int SQ_W       = 2 * OFF_W;
    localparam int RAD_W      = 36;
    localparam int ROOT_W     = 30;
    localparam int REM_W      = ROOT_W + 3;
    localparam int PROD_W     = ROOT_W + CFG_W;
    localparam int FRAC_SHIFT = 24;
    localparam int LEN_W      = 24;
    localparam int DLY_W      = 24;
    localparam int DIVN_W     = LEN_W + 8;
    localparam int RATIO_W    = 16;
    localparam int PHASE_W    = 3;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = DIVN_W;
    localparam int CNT_W      = 5;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_MOVE  = 2'd1,
        OP_START = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PEN_KEEP  = 2'd0,
        PEN_LOWER = 2'd1,
        PEN_LIFT  = 2'd2
    } t_pen;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SURFACE_WIDTH = 3'd0,
        CFG_LEFT_MARGIN   = 3'd1,
        CFG_TOP_MARGIN    = 3'd2,
        CFG_USABLE_WIDTH  = 3'd3,
        CFG_USABLE_HEIGHT = 3'd4,
        CFG_STEPS_PER_MM  = 3'd5,
        CFG_BASE_DELAY    = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_SCALE,
        S_DIFF,
        S_DIVIDE,
        S_DELAY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic imm;
        logic cap_move;
        logic cap_start;
        logic square;
        logic sum;
        logic root;
        logic scale_start;
        logic scale_move;
        logic diff;
        logic divide;
        logic delay;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_status;

endpackage

// ===== rtl/ppsg_if.sv =====
`timescale 1ns / 1ps

interface ppsg_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic               pen_wanted;

    modport source (output valid, op, target_x, target_y, pen_wanted, input ready);
    modport sink (input valid, op, target_x, target_y, pen_wanted, output ready);
endinterface

interface ppsg_result_if;
    logic       valid;
    logic       ready;
    logic       left_step;
    logic       left_lengthen;
    logic [2:0] left_phase;
    logic       right_step;
    logic       right_lengthen;
    logic [2:0] right_phase;
    logic [1:0] pen_command;
    logic       busy_res;
    logic       clamped;

    modport source (output valid, left_step, left_lengthen, left_phase, right_step,
                    right_lengthen, right_phase, pen_command, busy_res, clamped,
                    input ready);
    modport sink (input valid, left_step, left_lengthen, left_phase, right_step,
                  right_lengthen, right_phase, pen_command, busy_res, clamped,
                  output ready);
endinterface

// ===== rtl/ppsg_controller.sv =====
`timescale 1ns / 1ps

module ppsg_controller
    import ppsg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_op,
    input  logic       i_out_ready,
    input  t_status    i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_move, n_move;
    logic              r_out_valid, n_out_valid;
    logic              set_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_move      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_move      <= n_move;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_move     = r_move;
        o_cmd      = '0;
        set_out    = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                if (i_in_valid && o_in_ready) begin
                    if (t_op'(i_op) == OP_START) begin
                        o_cmd.cap_start = 1'b1;
                        n_move          = 1'b0;
                        n_state         = S_SQUARE;
                    end else if (t_op'(i_op) == OP_MOVE && !i_status.busy) begin
                        o_cmd.cap_move = 1'b1;
                        n_move         = 1'b1;
                        n_state        = S_SQUARE;
                    end else begin
                        o_cmd.imm = 1'b1;
                        set_out   = 1'b1;
                    end
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_cnt     = '0;
                n_state   = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_STEPS - 1)) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                if (r_move) begin
                    o_cmd.scale_move = 1'b1;
                    n_state          = S_DIFF;
                end else begin
                    o_cmd.scale_start = 1'b1;
                    n_state           = S_DONE;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_cnt      = '0;
                n_state    = S_DIVIDE;
            end
            S_DIVIDE: begin
                o_cmd.divide = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DELAY;
                end
            end
            S_DELAY: begin
                o_cmd.delay = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                set_out      = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (set_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/ppsg_datapath.sv =====
`timescale 1ns / 1ps

module ppsg_datapath
    import ppsg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [1:0]           i_op,
    input  logic signed [15:0]   i_target_x,
    input  logic signed [15:0]   i_target_y,
    input  logic                 i_pen_wanted,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output logic                 o_left_step,
    output logic                 o_left_lengthen,
    output logic [PHASE_W-1:0]   o_left_phase,
    output logic                 o_right_step,
    output logic                 o_right_lengthen,
    output logic [PHASE_W-1:0]   o_right_phase,
    output logic [1:0]           o_pen_command,
    output logic                 o_busy_res,
    output logic                 o_clamped
);

    logic [CFG_W-1:0] r_surface_width, r_left_margin, r_top_margin;
    logic [CFG_W-1:0] r_usable_width, r_usable_height, r_steps_per_mm, r_base_delay;

    // Index 0 is the left motor and index 1 the right motor.
    logic [LEN_W-1:0] r_len   [2];
    logic [LEN_W-1:0] r_steps [2];
    logic             r_dir   [2];
    logic [DLY_W-1:0] r_dly   [2];
    logic [DLY_W-1:0] r_el    [2];
    logic             r_pen_down;

    logic [COORD_W-1:0] r_x, r_y;
    t_pen               r_pen_cmd;
    logic               r_clip;
    logic [SQ_W-1:0]    r_sq_l, r_sq_r, r_sq_y;
    logic [RAD_W-1:0]   r_rad  [2];
    logic [REM_W-1:0]   r_rem  [2];
    logic [ROOT_W-1:0]  r_root [2];
    logic [LEN_W-1:0]   r_new  [2];
    logic               r_left_fast;
    logic [DIVN_W-1:0]  r_div_n;
    logic [LEN_W-1:0]   r_div_d;
    logic [LEN_W-1:0]   r_div_r;
    logic [DIVN_W-1:0]  r_quot;

    logic               r_o_lstep, r_o_rstep, r_o_ldir, r_o_rdir, r_o_busy, r_o_clip;
    logic [PHASE_W-1:0] r_o_lph, r_o_rph;
    t_pen               r_o_pen;

    logic               x_neg, x_over, y_neg, y_over, clip;
    logic [COORD_W-1:0] cx, cy;
    logic               want;
    t_pen               pen_cmd;
    logic [OFF_W-1:0]   dxl, dxr, dy;
    logic [OFF_W:0]     dxr_s;
    logic [SQ_W-1:0]    sq_l, sq_r, sq_y;
    logic [REM_W-1:0]   rem_sh [2];
    logic [REM_W-1:0]   trial  [2];
    logic               fits   [2];
    logic [PROD_W-1:0]  prod   [2];
    logic [LEN_W-1:0]   new_len [2];
    logic               grow   [2];
    logic [LEN_W-1:0]   span   [2];
    logic               left_fast;
    logic [LEN_W:0]     div_t, div_sub;
    logic               div_ge;
    logic [RATIO_W-1:0] ratio;
    logic [2*CFG_W-1:0] slow_prod;
    logic [DLY_W-1:0]   slow, base;
    logic               do_tick;
    logic               t_step [2];
    logic [DLY_W-1:0]   el1    [2];
    logic [LEN_W-1:0]   len_nx [2];
    logic [LEN_W-1:0]   steps_nx [2];
    logic [DLY_W-1:0]   el_nx  [2];
    logic               busy_nx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surface_width <= CFG_W'(16000);
            r_left_margin   <= CFG_W'(2880);
            r_top_margin    <= CFG_W'(4000);
            r_usable_width  <= CFG_W'(10240);
            r_usable_height <= CFG_W'(8000);
            r_steps_per_mm  <= CFG_W'(2560);
            r_base_delay    <= CFG_W'(1000);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SURFACE_WIDTH: r_surface_width <= i_cfg_data;
                CFG_LEFT_MARGIN:   r_left_margin   <= i_cfg_data;
                CFG_TOP_MARGIN:    r_top_margin    <= i_cfg_data;
                CFG_USABLE_WIDTH:  r_usable_width  <= i_cfg_data;
                CFG_USABLE_HEIGHT: r_usable_height <= i_cfg_data;
                CFG_STEPS_PER_MM:  r_steps_per_mm  <= i_cfg_data;
                CFG_BASE_DELAY:    r_base_delay    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        x_neg  = i_target_x[COORD_W-1];
        y_neg  = i_target_y[COORD_W-1];
        x_over = !x_neg && ({1'b0, i_target_x[COORD_W-2:0]} > r_usable_width);
        y_over = !y_neg && ({1'b0, i_target_y[COORD_W-2:0]} > r_usable_height);
        cx     = x_neg ? '0 : (x_over ? r_usable_width : {1'b0, i_target_x[COORD_W-2:0]});
        cy     = y_neg ? '0 : (y_over ? r_usable_height : {1'b0, i_target_y[COORD_W-2:0]});
        clip   = x_neg || x_over || y_neg || y_over;
        want   = i_pen_wanted && !clip;
        if (want && !r_pen_down) begin
            pen_cmd = PEN_LOWER;
        end else if (!want && r_pen_down) begin
            pen_cmd = PEN_LIFT;
        end else begin
            pen_cmd = PEN_KEEP;
        end

        dxl   = {1'b0, r_x} + {1'b0, r_left_margin};
        dxr_s = {2'b00, r_surface_width} - {2'b00, r_x} - {2'b00, r_left_margin};
        dxr   = dxr_s[OFF_W] ? OFF_W'(-dxr_s) : dxr_s[OFF_W-1:0];
        dy    = {1'b0, r_y} + {1'b0, r_top_margin};
        sq_l  = dxl * dxl;
        sq_r  = dxr * dxr;
        sq_y  = dy * dy;

        for (int k = 0; k < 2; k++) begin
            rem_sh[k]  = {r_rem[k][REM_W-3:0], r_rad[k][RAD_W-1 -: 2]};
            trial[k]   = {1'b0, r_root[k], 2'b01};
            fits[k]    = rem_sh[k] >= trial[k];
            prod[k]    = r_root[k] * r_steps_per_mm;
            new_len[k] = LEN_W'(prod[k][PROD_W-1:FRAC_SHIFT]);
            grow[k]    = r_new[k] > r_len[k];
            span[k]    = grow[k] ? (r_new[k] - r_len[k]) : (r_len[k] - r_new[k]);
        end
        left_fast = span[0] > span[1];

        div_t   = {r_div_r, r_div_n[DIVN_W-1]};
        div_sub = div_t - {1'b0, r_div_d};
        div_ge  = div_t >= {1'b0, r_div_d};

        ratio     = (|r_quot[DIVN_W-1:RATIO_W]) ? '1 : r_quot[RATIO_W-1:0];
        slow_prod = r_base_delay * ratio;
        slow      = slow_prod[2*CFG_W-1:8];
        base      = DLY_W'(r_base_delay);

        do_tick = i_cmd.imm && (t_op'(i_op) == OP_TICK);
        for (int k = 0; k < 2; k++) begin
            el1[k]      = r_el[k] + 1'b1;
            t_step[k]   = do_tick && (r_steps[k] != '0) && (el1[k] >= r_dly[k]);
            len_nx[k]   = r_len[k];
            steps_nx[k] = r_steps[k];
            el_nx[k]    = r_el[k];
            if (do_tick && (r_steps[k] != '0)) begin
                if (t_step[k]) begin
                    el_nx[k]    = '0;
                    steps_nx[k] = r_steps[k] - 1'b1;
                    len_nx[k]   = r_dir[k] ? (r_len[k] + 1'b1) : (r_len[k] - 1'b1);
                end else begin
                    el_nx[k] = el1[k];
                end
            end
        end
        busy_nx = (steps_nx[0] != '0) || (steps_nx[1] != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_len[k]   <= '0;
                r_steps[k] <= '0;
                r_dir[k]   <= 1'b0;
                r_dly[k]   <= '0;
                r_el[k]    <= '0;
            end
            r_pen_down <= 1'b1;
        end else begin
            if (i_cmd.imm) begin
                for (int k = 0; k < 2; k++) begin
                    r_len[k]   <= len_nx[k];
                    r_steps[k] <= steps_nx[k];
                    r_el[k]    <= el_nx[k];
                end
            end
            if (i_cmd.cap_move) begin
                r_pen_down <= want;
            end
            if (i_cmd.scale_start) begin
                for (int k = 0; k < 2; k++) begin
                    r_len[k]   <= new_len[k];
                    r_steps[k] <= '0;
                    r_dly[k]   <= '0;
                    r_el[k]    <= '0;
                end
            end
            if (i_cmd.diff) begin
                for (int k = 0; k < 2; k++) begin
                    r_dir[k]   <= grow[k];
                    r_steps[k] <= span[k];
                end
            end
            if (i_cmd.delay) begin
                r_dly[0] <= r_left_fast ? base : slow;
                r_dly[1] <= r_left_fast ? slow : base;
                r_el[0]  <= '0;
                r_el[1]  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_move) begin
            r_x       <= cx;
            r_y       <= cy;
            r_pen_cmd <= pen_cmd;
            r_clip    <= clip;
        end
        if (i_cmd.cap_start) begin
            r_x       <= {1'b0, r_usable_width[CFG_W-1:1]};
            r_y       <= {1'b0, r_usable_height[CFG_W-1:1]};
            r_pen_cmd <= PEN_KEEP;
            r_clip    <= 1'b0;
        end
        if (i_cmd.square) begin
            r_sq_l <= sq_l;
            r_sq_r <= sq_r;
            r_sq_y <= sq_y;
        end
        if (i_cmd.sum) begin
            r_rad[0]  <= RAD_W'(r_sq_l) + RAD_W'(r_sq_y);
            r_rad[1]  <= RAD_W'(r_sq_r) + RAD_W'(r_sq_y);
            r_rem[0]  <= '0;
            r_rem[1]  <= '0;
            r_root[0] <= '0;
            r_root[1] <= '0;
        end
        if (i_cmd.root) begin
            for (int k = 0; k < 2; k++) begin
                r_rem[k]  <= fits[k] ? (rem_sh[k] - trial[k]) : rem_sh[k];
                r_root[k] <= {r_root[k][ROOT_W-2:0], fits[k]};
                r_rad[k]  <= {r_rad[k][RAD_W-3:0], 2'b00};
            end
        end
        if (i_cmd.scale_move) begin
            r_new[0] <= new_len[0];
            r_new[1] <= new_len[1];
        end
        if (i_cmd.diff) begin
            r_left_fast <= left_fast;
            r_div_n     <= {(left_fast ? span[0] : span[1]), 8'h00};
            r_div_d     <= left_fast ? span[1] : span[0];
            r_div_r     <= '0;
            r_quot      <= '0;
        end
        if (i_cmd.divide) begin
            r_div_r <= div_ge ? div_sub[LEN_W-1:0] : div_t[LEN_W-1:0];
            r_div_n <= {r_div_n[DIVN_W-2:0], 1'b0};
            r_quot  <= {r_quot[DIVN_W-2:0], div_ge};
        end
        if (i_cmd.imm) begin
            r_o_lstep <= t_step[0];
            r_o_rstep <= t_step[1];
            r_o_ldir  <= r_dir[0];
            r_o_rdir  <= r_dir[1];
            r_o_lph   <= len_nx[0][PHASE_W-1:0];
            r_o_rph   <= len_nx[1][PHASE_W-1:0];
            r_o_pen   <= PEN_KEEP;
            r_o_busy  <= busy_nx;
            r_o_clip  <= 1'b0;
        end
        if (i_cmd.finish) begin
            r_o_lstep <= 1'b0;
            r_o_rstep <= 1'b0;
            r_o_ldir  <= r_dir[0];
            r_o_rdir  <= r_dir[1];
            r_o_lph   <= r_len[0][PHASE_W-1:0];
            r_o_rph   <= r_len[1][PHASE_W-1:0];
            r_o_pen   <= r_pen_cmd;
            r_o_busy  <= (r_steps[0] != '0) || (r_steps[1] != '0);
            r_o_clip  <= r_clip;
        end
    end

    assign o_status.busy    = (r_steps[0] != '0) || (r_steps[1] != '0);
    assign o_left_step      = r_o_lstep;
    assign o_left_lengthen  = r_o_ldir;
    assign o_left_phase     = r_o_lph;
    assign o_right_step     = r_o_rstep;
    assign o_right_lengthen = r_o_rdir;
    assign o_right_phase    = r_o_rph;
    assign o_pen_command    = r_o_pen;
    assign o_busy_res       = r_o_busy;
    assign o_clamped        = r_o_clip;

endmodule

// ===== rtl/polar_plotter_step_generator_unit.sv =====
// A tick, an ignored move or a no-op gives its result in the cycle after the transfer. A start
// runs the square, sum, root and scale states; an accepted move adds diff, divide and delay. Two
// 30-step square-root lanes and a 32-step restoring divider work one bit per cycle.
// Ticks sustain one item per cycle while output is taken; long items are handled one at a time.
// Reset is synchronous and active low; it restores the configuration defaults and clears motion.
`timescale 1ns / 1ps

module polar_plotter_step_generator_unit
    import ppsg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    ppsg_item_if.sink            i_item,
    ppsg_result_if.source        o_result
);

    t_cmd    cmd;
    t_status status;

    ppsg_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_op        (i_item.op),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (cmd)
    );

    ppsg_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_op             (i_item.op),
        .i_target_x       (i_item.target_x),
        .i_target_y       (i_item.target_y),
        .i_pen_wanted     (i_item.pen_wanted),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_left_step      (o_result.left_step),
        .o_left_lengthen  (o_result.left_lengthen),
        .o_left_phase     (o_result.left_phase),
        .o_right_step     (o_result.right_step),
        .o_right_lengthen (o_result.right_lengthen),
        .o_right_phase    (o_result.right_phase),
        .o_pen_command    (o_result.pen_command),
        .o_busy_res       (o_result.busy_res),
        .o_clamped        (o_result.clamped)
    );

endmodule

// ===== rtl/ppsg_checker.sv =====
`timescale 1ns / 1ps
`include "polar_plotter_step_generator_unit_assert.svh"

module ppsg_checker
    import ppsg_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic       i_lstep,
    input logic       i_rstep,
    input logic [1:0] i_pen,
    input logic       i_clip
);

    `PPSG_ASSERT_IMPLY(a_pen_code, i_clk, i_rst_n, i_valid, i_pen <= PEN_LIFT)
    `PPSG_ASSERT_IMPLY(a_clip_lifts, i_clk, i_rst_n, i_valid && i_clip, i_pen != PEN_LOWER)
    `PPSG_ASSERT_IMPLY(a_step_only_tick, i_clk, i_rst_n, i_valid && (i_lstep || i_rstep), i_pen == PEN_KEEP && !i_clip)
    `PPSG_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_pen) && $stable(i_clip))

endmodule

bind polar_plotter_step_generator_unit ppsg_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_result.valid),
    .i_ready (o_result.ready),
    .i_lstep (o_result.left_step),
    .i_rstep (o_result.right_step),
    .i_pen   (o_result.pen_command),
    .i_clip  (o_result.clamped)
);
